// ===== rtl/cmp_pkg.sv =====
// ---------------------------------------------------------------------------
// cmp_pkg: shared constants for the cycloidal motion profile unit
// CORDIC angle table in turns, fixed-point constants and register indexes
// ---------------------------------------------------------------------------
package cmp_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 2'd2;

    // profile modes
    localparam logic MODE_SIN = 1'b0;
    localparam logic MODE_LIN = 1'b1;

    // cordic datapath widths
    localparam int XY_W = 32;
    localparam int Z_W  = 33;
    localparam int ATAN_N = 24;

    // fixed-point constants
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [31:0] CORDIC_GAIN    = 32'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    // output item layout
    localparam int POS_W  = 32;
    localparam int VEL_W  = 42;
    localparam int OUT_W  = 80;

    // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// ===== rtl/cmp_div_cell.sv =====
// ---------------------------------------------------------------------------
// cmp_div_cell: one restoring division step
// shifts one dividend bit into the remainder and one quotient bit into acc
// ---------------------------------------------------------------------------
module cmp_div_cell #(
    parameter int DW = 16,
    parameter int AW = 32,
    parameter int PW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_div,
    input  logic [DW-1:0] i_rem,
    input  logic [AW-1:0] i_acc,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_rem,
    output logic [AW-1:0] o_acc,
    output logic [PW-1:0] o_pay
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [AW-1:0] r_acc;
    logic [PW-1:0] r_pay;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [AW-1:0] n_acc;

    // trial subtract of the divisor
    always_comb begin
        shifted = {i_rem, i_acc[AW-1]};
        diff    = shifted - {1'b0, i_div};
        ge      = (shifted >= {1'b0, i_div});
        n_rem   = ge ? diff[DW-1:0] : shifted[DW-1:0];
        n_acc   = {i_acc[AW-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_pay   = r_pay;

endmodule

// ===== rtl/cmp_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// cmp_cordic_cell: one CORDIC micro-rotation in rotation mode
// angle in turns, shift and table entry fixed by the cell's place
// ---------------------------------------------------------------------------
module cmp_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = 33
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [cmp_pkg::XY_W-1:0] i_x,
    input  logic signed [cmp_pkg::XY_W-1:0] i_y,
    input  logic signed [cmp_pkg::Z_W-1:0]  i_z,
    input  logic [PW-1:0]                   i_pay,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [cmp_pkg::XY_W-1:0] o_x,
    output logic signed [cmp_pkg::XY_W-1:0] o_y,
    output logic signed [cmp_pkg::Z_W-1:0]  o_z,
    output logic [PW-1:0]                   o_pay
);
    import cmp_pkg::*;

    logic                   r_valid;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [PW-1:0]          r_pay;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;
    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;

    // rotate towards zero residual angle
    always_comb begin
        dx  = i_y >>> STEP;
        dy  = i_x >>> STEP;
        ang = $signed({1'b0, ATAN_TURNS[STEP]});
        if (!i_z[Z_W-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ang;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ang;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_pay   = r_pay;

endmodule

// ===== rtl/cycloidal_motion_profile_unit.sv =====
// ---------------------------------------------------------------------------
// cycloidal_motion_profile_unit: single-axis move profile generator
// position and velocity of a cycloidal or linear move at a given tick
// ---------------------------------------------------------------------------
// usage
//   configuration: write i_cfg_we with i_cfg_idx 0 mode, 1 period, 2 distance
//   while the unit is idle; writes take effect on the next item
//   input items: i_s_tdata carries elapsed_ticks, one item per tvalid/tready
//   output items: o_m_tdata carries position_q8, velocity_q16, move_done
//   structure: input stage, 32 phase division cells, fold register, CORDIC
//   cells, unfold, scale, fraction and product registers, velocity division
//   cells and output register; one bit or one rotation per cell
//   throughput: one item per cycle while the output is taken (i_m_tready high)
//   stall: each cell holds while its successor is full and stalled, bubbles
//   close up, so items are still taken until the whole chain is full
//   reset: i_rst_n low clears every valid bit; mode 0, period 1, distance 0
// ---------------------------------------------------------------------------
module cycloidal_motion_profile_unit #(
    parameter int TIME_BITS    = 16,
    parameter int DIST_BITS    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [cmp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((TIME_BITS > DIST_BITS) ? TIME_BITS : DIST_BITS)-1:0] i_cfg_data,
    // input items
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]        i_s_tdata,  // elapsed_ticks
    // output items
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [cmp_pkg::OUT_W-1:0]             o_m_tdata   // position_q8, velocity_q16,
                                                              // move_done
);
    import cmp_pkg::*;

    localparam int TW  = TIME_BITS;
    localparam int DB  = DIST_BITS;
    localparam int VW  = DB + 17;
    localparam int PPW = DB + 31;
    localparam int QB  = 32;
    localparam int CPW = 33;

    // configuration registers
    logic          r_mode;
    logic [TW-1:0] r_period;
    logic [DB-1:0] r_dist;
    logic [TW-1:0] teff;
    logic          dneg;
    logic [DB-1:0] dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SIN;
            r_period <= TW'(1);
            r_dist   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_PERIOD: r_period <= i_cfg_data[TW-1:0];
                CFG_DIST:   r_dist   <= i_cfg_data[DB-1:0];
                default:    ;
            endcase
        end
    end

    assign teff = (r_period == '0) ? TW'(1) : r_period;
    assign dneg = r_dist[DB-1];
    assign dmag = dneg ? (~r_dist + DB'(1)) : r_dist;

    // input stage: top quotient bit and done flag
    logic          r0_v;
    logic [TW-1:0] r0_rem;
    logic          r0_q32;
    logic          r0_done;
    logic [TW-1:0] in_t;
    logic          rdy0;

    assign in_t       = i_s_tdata[TW-1:0];
    assign o_s_tready = !r0_v || rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (o_s_tready) begin
            r0_v <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r0_q32  <= (in_t >= teff);
            r0_rem  <= (in_t >= teff) ? (in_t - teff) : in_t;
            r0_done <= (in_t > teff);
        end
    end

    // phase division chain: floor(t * 2^32 / T)
    logic          d1_v   [QB+1];
    logic          d1_rdy [QB+1];
    logic [TW-1:0] d1_rem [QB+1];
    logic [QB-1:0] d1_acc [QB+1];
    logic [1:0]    d1_pay [QB+1];
    logic          rdy1;

    assign d1_v[0]   = r0_v;
    assign d1_rem[0] = r0_rem;
    assign d1_acc[0] = '0;
    assign d1_pay[0] = {r0_done, r0_q32};
    assign rdy0      = d1_rdy[0];
    assign d1_rdy[QB] = rdy1;

    for (genvar k = 0; k < QB; k++) begin : g_div1
        cmp_div_cell #(.DW(TW), .AW(QB), .PW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d1_v[k]),
            .o_ready (d1_rdy[k]),
            .i_div   (teff),
            .i_rem   (d1_rem[k]),
            .i_acc   (d1_acc[k]),
            .i_pay   (d1_pay[k]),
            .o_valid (d1_v[k+1]),
            .i_ready (d1_rdy[k+1]),
            .o_rem   (d1_rem[k+1]),
            .o_acc   (d1_acc[k+1]),
            .o_pay   (d1_pay[k+1])
        );
    end

    // fold the phase into a quarter turn either side of zero
    logic                  r1_v;
    logic signed [Z_W-1:0] r1_z;
    logic                  r1_neg;
    logic [30:0]           r1_lin;
    logic                  r1_done;
    logic signed [Z_W-1:0] z0;
    logic signed [Z_W-1:0] n1_z;
    logic                  n1_neg;
    logic                  rdy2c;
    logic                  en1;

    always_comb begin
        z0     = Z_W'($signed(d1_acc[QB]));
        n1_z   = z0;
        n1_neg = 1'b0;
        if (z0 > $signed(Z_W'(64'sd1073741824))) begin
            n1_z   = z0 - $signed(Z_W'(64'sd2147483648));
            n1_neg = 1'b1;
        end else if (z0 < -$signed(Z_W'(64'sd1073741824))) begin
            n1_z   = z0 + $signed(Z_W'(64'sd2147483648));
            n1_neg = 1'b1;
        end
    end

    assign en1  = !r1_v || rdy2c;
    assign rdy1 = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= d1_v[QB];
        end
        if (en1 && d1_v[QB]) begin
            r1_z    <= n1_z;
            r1_neg  <= n1_neg;
            r1_lin  <= {d1_pay[QB][0], d1_acc[QB][QB-1:2]};
            r1_done <= d1_pay[QB][1];
        end
    end

    // cordic chain
    logic                   c_v   [CORDIC_STEPS+1];
    logic                   c_rdy [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_x   [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_y   [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  c_z   [CORDIC_STEPS+1];
    logic [CPW-1:0]         c_pay [CORDIC_STEPS+1];
    logic                   rdy2;

    assign c_v[0]   = r1_v;
    assign c_x[0]   = $signed(CORDIC_GAIN);
    assign c_y[0]   = '0;
    assign c_z[0]   = r1_z;
    assign c_pay[0] = {r1_done, r1_neg, r1_lin};
    assign rdy2c    = c_rdy[0];
    assign c_rdy[CORDIC_STEPS] = rdy2;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        cmp_cordic_cell #(.STEP(k), .PW(CPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[k]),
            .o_ready (c_rdy[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_pay   (c_pay[k]),
            .o_valid (c_v[k+1]),
            .i_ready (c_rdy[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_pay   (c_pay[k+1])
        );
    end

    // undo the fold and clamp sine and cosine to one
    logic                   r2_v;
    logic [30:0]            r2_smag;
    logic                   r2_sneg;
    logic signed [XY_W-1:0] r2_cs;
    logic [30:0]            r2_lin;
    logic                   r2_done;
    logic signed [XY_W-1:0] xn;
    logic signed [XY_W-1:0] yn;
    logic signed [XY_W-1:0] xc;
    logic signed [XY_W-1:0] yc;
    logic signed [XY_W-1:0] one_s;
    logic                   rdy3;
    logic                   en2;

    assign one_s = $signed(XY_W'(Q30_ONE));

    always_comb begin
        xn = c_pay[CORDIC_STEPS][31] ? -c_x[CORDIC_STEPS] : c_x[CORDIC_STEPS];
        yn = c_pay[CORDIC_STEPS][31] ? -c_y[CORDIC_STEPS] : c_y[CORDIC_STEPS];
        xc = xn;
        yc = yn;
        if (xn > one_s) xc = one_s;
        if (xn < -one_s) xc = -one_s;
        if (yn > one_s) yc = one_s;
        if (yn < -one_s) yc = -one_s;
    end

    assign en2  = !r2_v || rdy3;
    assign rdy2 = en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= c_v[CORDIC_STEPS];
        end
        if (en2 && c_v[CORDIC_STEPS]) begin
            r2_sneg <= yc[XY_W-1];
            r2_smag <= yc[XY_W-1] ? 31'(-yc) : 31'(yc);
            r2_cs   <= xc;
            r2_lin  <= c_pay[CORDIC_STEPS][30:0];
            r2_done <= c_pay[CORDIC_STEPS][32];
        end
    end

    // sine over two pi, and distance times one minus cosine
    logic             r3_v;
    logic [29:0]      r3_g;
    logic             r3_sneg;
    logic [DB+31:0]   r3_vprod;
    logic [30:0]      r3_lin;
    logic             r3_done;
    logic [61:0]      gsum;
    logic [31:0]      omc;
    logic             rdy4;
    logic             en3;

    assign gsum = 62'(r2_smag * INV_TWO_PI_Q32) + 62'h8000_0000;
    assign omc  = 32'($signed(XY_W'(Q30_ONE)) - r2_cs);
    assign en3  = !r3_v || rdy4;
    assign rdy3 = en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
        if (en3 && r2_v) begin
            r3_g     <= gsum[61:32];
            r3_sneg  <= r2_sneg;
            r3_vprod <= (DB+32)'(dmag * omc);
            r3_lin   <= r2_lin;
            r3_done  <= r2_done;
        end
    end

    // position fraction of the move
    logic              r4_v;
    logic [30:0]       r4_frac;
    logic [DB+31:0]    r4_vprod;
    logic              r4_done;
    logic signed [32:0] fs;
    logic [30:0]       n4_frac;
    logic              rdy5;
    logic              en4;

    always_comb begin
        fs = r3_sneg ? ($signed({2'b00, r3_lin}) + $signed({3'b000, r3_g}))
                     : ($signed({2'b00, r3_lin}) - $signed({3'b000, r3_g}));
        if (fs[32]) begin
            n4_frac = '0;
        end else if (fs > $signed({2'b00, Q30_ONE})) begin
            n4_frac = Q30_ONE;
        end else begin
            n4_frac = fs[30:0];
        end
        if (r_mode == MODE_LIN) n4_frac = r3_lin;
        if (r3_done) n4_frac = Q30_ONE;
    end

    assign en4  = !r4_v || rdy5;
    assign rdy4 = en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= r3_v;
        end
        if (en4 && r3_v) begin
            r4_frac  <= n4_frac;
            r4_vprod <= r3_vprod;
            r4_done  <= r3_done;
        end
    end

    // position product and velocity dividend
    logic           r5_v;
    logic [PPW-1:0] r5_pos;
    logic [VW-1:0]  r5_vdiv;
    logic           r5_done;
    logic           rdy6d;
    logic           en5;

    assign en5  = !r5_v || rdy6d;
    assign rdy5 = en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en5) begin
            r5_v <= r4_v;
        end
        if (en5 && r4_v) begin
            r5_pos  <= PPW'(dmag * r4_frac);
            r5_vdiv <= (r_mode == MODE_LIN) ? VW'({dmag, 16'h0000}) : r4_vprod[DB+30:14];
            r5_done <= r4_done;
        end
    end

    // velocity division chain: dividend over the period
    logic           d2_v   [VW+1];
    logic           d2_rdy [VW+1];
    logic [TW-1:0]  d2_rem [VW+1];
    logic [VW-1:0]  d2_acc [VW+1];
    logic [PPW:0]   d2_pay [VW+1];
    logic           rdy6;

    assign d2_v[0]   = r5_v;
    assign d2_rem[0] = '0;
    assign d2_acc[0] = r5_vdiv;
    assign d2_pay[0] = {r5_done, r5_pos};
    assign rdy6d     = d2_rdy[0];
    assign d2_rdy[VW] = rdy6;

    for (genvar k = 0; k < VW; k++) begin : g_div2
        cmp_div_cell #(.DW(TW), .AW(VW), .PW(PPW+1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d2_v[k]),
            .o_ready (d2_rdy[k]),
            .i_div   (teff),
            .i_rem   (d2_rem[k]),
            .i_acc   (d2_acc[k]),
            .i_pay   (d2_pay[k]),
            .o_valid (d2_v[k+1]),
            .i_ready (d2_rdy[k+1]),
            .o_rem   (d2_rem[k+1]),
            .o_acc   (d2_acc[k+1]),
            .o_pay   (d2_pay[k+1])
        );
    end

    // output register: rounding, sign and saturation
    logic              r6_v;
    logic [POS_W-1:0]  r6_pos;
    logic [VEL_W-1:0]  r6_vel;
    logic              r6_done;
    logic [PPW:0]      psum;
    logic [63:0]       pm64;
    logic [63:0]       vm64;
    logic [POS_W-1:0]  n6_pos;
    logic [VEL_W-1:0]  n6_vel;
    logic              en6;

    always_comb begin
        psum = {1'b0, d2_pay[VW][PPW-1:0]} + (PPW+1)'(22'h20_0000);
        pm64 = 64'(psum[PPW:22]);
        vm64 = 64'(d2_acc[VW]);
        if (dneg) begin
            n6_pos = (pm64 >= 64'h8000_0000) ? 32'h8000_0000 : POS_W'(~pm64 + 64'd1);
            n6_vel = (vm64 >= 64'h200_0000_0000) ? {1'b1, 41'd0}
                                                  : VEL_W'(~vm64 + 64'd1);
        end else begin
            n6_pos = (pm64 >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : POS_W'(pm64);
            n6_vel = (vm64 >= 64'h1FF_FFFF_FFFF) ? {1'b0, {41{1'b1}}} : VEL_W'(vm64);
        end
        if (d2_pay[VW][PPW]) n6_vel = '0;
    end

    assign en6  = !r6_v || i_m_tready;
    assign rdy6 = en6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en6) begin
            r6_v <= d2_v[VW];
        end
        if (en6 && d2_v[VW]) begin
            r6_pos  <= n6_pos;
            r6_vel  <= n6_vel;
            r6_done <= d2_pay[VW][PPW];
        end
    end

    assign o_m_tvalid = r6_v;
    assign o_m_tdata  = {(OUT_W-POS_W-VEL_W-1)'(0), r6_done, r6_vel, r6_pos};

endmodule
